// ----- hw/rtl/igfr_pkg.sv -----
// Package for the idle-gap frame receiver: shared types, register map and reset values.
// No dependencies; used by idle_gap_frame_receiver_core.
package igfr_pkg;

    // Default frame store depth
    localparam int DEFAULT_BUFFER_DEPTH = 64;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int LEN_W     = 7;
    localparam int INDEX_W   = 6;
    localparam int OUT_W     = 24;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd10;
    localparam logic [LEN_W-1:0]     MAX_LEN_RST      = 7'd64;

    // Silence counter saturation value
    localparam logic [TIMEOUT_W-1:0] SILENCE_MAX = 16'hFFFF;

    // Register map, selected by paddr[2]
    localparam logic REG_IDLE_TIMEOUT = 1'b0;
    localparam logic REG_MAX_LEN      = 1'b1;

    // Input beat kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

endpackage

// ----- hw/rtl/idle_gap_frame_receiver_core.sv -----
// Idle-gap frame receiver top level: frame store memory, silence counter and dump sequencer.
// Depends on igfr_pkg.
//
// The block collects received UART bytes (tuser = 0) in a single-port-write, single-port-read
// frame store and counts time ticks (tuser = 1) of line silence. When bytes are held and the
// silence reaches idle_timeout, the tick starts a frame dump: the first min(stored bytes,
// max_frame_len) bytes leave in ascending order, one beat per cycle at best, with tlast on the
// final one. Byte and non-delivering tick beats leave s_tready high. A delivering tick holds
// s_tready low until all L entries of the frame, L being the frame length, are read through
// the one read port, one entry per free output slot; a stalled m_tready prolongs it. A zero
// max_frame_len discards the held bytes without output. Bytes arriving at a full store are
// dropped. Registers: idle_timeout at 0x0 (16 bit, reset 10), max_frame_len at 0x4 (7 bit,
// reset 64). No clearing pass is needed after reset.
module idle_gap_frame_receiver_core #(
    parameter int BUFFER_DEPTH = igfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                   // [20:14] frame_length, [23:21] zero
    output logic        m_tlast,   // last_of_frame
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [igfr_pkg::LEN_W-1:0] DEPTH_C = igfr_pkg::LEN_W'(BUFFER_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t                             state_reg, state_next;
    logic [igfr_pkg::LEN_W-1:0]         byte_count_reg, byte_count_next;
    logic [igfr_pkg::TIMEOUT_W-1:0]     silence_reg, silence_next;
    logic [igfr_pkg::TIMEOUT_W-1:0]     idle_timeout_reg, idle_timeout_next;
    logic [igfr_pkg::LEN_W-1:0]         max_len_reg, max_len_next;
    logic [igfr_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [igfr_pkg::LEN_W-1:0]         issue_reg, issue_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [igfr_pkg::INDEX_W-1:0]       index_reg, index_next;
    logic [igfr_pkg::LEN_W-1:0]         out_len_reg, out_len_next;
    logic                               last_reg, last_next;

    logic [igfr_pkg::BYTE_W-1:0]        mem [BUFFER_DEPTH];
    logic [igfr_pkg::BYTE_W-1:0]        rdata_reg;
    logic                               mem_we;
    logic                               mem_re;
    logic [AW-1:0]                      mem_raddr;

    logic                               s_accept;
    logic                               cfg_write;
    logic                               out_free;
    logic [igfr_pkg::TIMEOUT_W-1:0]     silence_inc;
    logic [igfr_pkg::LEN_W-1:0]         frame_len;
    logic                               deliver;

    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Saturating silence increment and delivery decision for a tick
    assign silence_inc = (silence_reg == igfr_pkg::SILENCE_MAX) ?
                         silence_reg : silence_reg + igfr_pkg::TIMEOUT_W'(1);
    assign frame_len   = (byte_count_reg > max_len_reg) ? max_len_reg : byte_count_reg;
    assign deliver     = (byte_count_reg != '0) && (silence_inc >= idle_timeout_reg);

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            igfr_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, idle_timeout_reg};
            igfr_pkg::REG_MAX_LEN:      prdata = {25'd0, max_len_reg};
            default:                    prdata = '0;
        endcase
    end

    // Next-state logic: collect, count silence, sequence the dump
    always_comb
    begin
        state_next        = state_reg;
        byte_count_next   = byte_count_reg;
        silence_next      = silence_reg;
        idle_timeout_next = idle_timeout_reg;
        max_len_next      = max_len_reg;
        len_next          = len_reg;
        issue_next        = issue_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        index_next        = index_reg;
        out_len_next      = out_len_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_raddr         = issue_reg[AW-1:0];

        if (cfg_write)
        begin
            unique case (paddr[2])
                igfr_pkg::REG_IDLE_TIMEOUT: idle_timeout_next = pwdata[15:0];
                igfr_pkg::REG_MAX_LEN:      max_len_next = pwdata[6:0];
                default:                    max_len_next = max_len_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (igfr_pkg::opcode_t'(s_tuser) == igfr_pkg::OP_BYTE)
                    begin
                        // Store the byte unless the store is full
                        if (byte_count_reg < DEPTH_C)
                        begin
                            mem_we          = 1'b1;
                            byte_count_next = byte_count_reg + igfr_pkg::LEN_W'(1);
                            silence_next    = '0;
                        end
                    end
                    else
                    begin
                        silence_next = silence_inc;
                        if (deliver)
                        begin
                            byte_count_next = '0;
                            silence_next    = '0;
                            len_next        = frame_len;
                            issue_next      = '0;
                            if (frame_len != '0)
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                    end
                end
            end
            ST_DUMP:
            begin
                // Issue one read per free output slot; the read data lands in the output
                if (out_free)
                begin
                    mem_re        = 1'b1;
                    m_tvalid_next = 1'b1;
                    index_next    = issue_reg[igfr_pkg::INDEX_W-1:0];
                    out_len_next  = len_reg;
                    last_next     = (issue_reg + igfr_pkg::LEN_W'(1) == len_reg);
                    issue_next    = issue_reg + igfr_pkg::LEN_W'(1);
                    if (issue_reg + igfr_pkg::LEN_W'(1) == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            byte_count_reg   <= '0;
            silence_reg      <= '0;
            idle_timeout_reg <= igfr_pkg::IDLE_TIMEOUT_RST;
            max_len_reg      <= igfr_pkg::MAX_LEN_RST;
            len_reg          <= '0;
            issue_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            index_reg        <= '0;
            out_len_reg      <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            byte_count_reg   <= byte_count_next;
            silence_reg      <= silence_next;
            idle_timeout_reg <= idle_timeout_next;
            max_len_reg      <= max_len_next;
            len_reg          <= len_next;
            issue_reg        <= issue_next;
            m_tvalid_reg     <= m_tvalid_next;
            index_reg        <= index_next;
            out_len_reg      <= out_len_next;
            last_reg         <= last_next;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[byte_count_reg[AW-1:0]] <= s_tdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'd0, out_len_reg, index_reg, rdata_reg};

`ifndef SYNTHESIS
    // The fill level never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= DEPTH_C)
        else $error("byte count beyond store depth");

    // The final beat of a frame is only presented once all its reads are issued
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && last_reg) |-> ((state_reg == ST_IDLE) || (issue_reg == '0)))
        else $error("last beat shown while dump still issuing");

    // A dump runs with a non-zero length and never issues past it
    a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> ((len_reg != '0) && (issue_reg < len_reg)))
        else $error("dump index out of frame");

    // A delivering tick leaves the store empty and the silence cleared
    a_deliver_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == igfr_pkg::OP_TICK) && deliver)
        |=> ((byte_count_reg == '0) && (silence_reg == '0)))
        else $error("delivery did not clear count and silence");
`endif

endmodule

// ----- tb/sv/igfr_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Frame scoreboard for the idle-gap frame receiver testbench: byte/tick predictor and output check.
// Depends on igfr_pkg for field widths, reset values and beat kinds.
package igfr_scoreboard_pkg;

    import igfr_pkg::*;

    localparam int STORE_DEPTH  = DEFAULT_BUFFER_DEPTH;
    localparam int REPORT_LIMIT = 10;

    // One delivered frame beat as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [LEN_W-1:0]   frame_length;
        logic               last;
    } frame_beat_t;

    class frame_scoreboard;
        logic [TIMEOUT_W-1:0] idle_timeout;
        logic [LEN_W-1:0]     max_len;
        logic [BYTE_W-1:0]    frame_mem [STORE_DEPTH];
        int                   held;
        int                   silence;
        frame_beat_t          frame_beats [$];
        int                   mismatches;

        function new();
            idle_timeout = IDLE_TIMEOUT_RST;
            max_len      = MAX_LEN_RST;
            held         = 0;
            silence      = 0;
            mismatches   = 0;
        endfunction

        // Advance the frame state by one accepted input beat and queue any frame it releases
        function void note_beat(opcode_t op, logic [BYTE_W-1:0] rx);
            int          len;
            frame_beat_t fb;
            if (op == OP_BYTE) begin
                // Drop the byte when the store is full, keeping the silence count
                if (held < STORE_DEPTH) begin
                    frame_mem[held] = rx;
                    held++;
                    silence = 0;
                end
                return;
            end
            if (silence < SILENCE_MAX)
                silence++;
            if (held != 0 && silence >= idle_timeout) begin
                len = (held > max_len) ? max_len : held;
                for (int i = 0; i < len; i++) begin
                    fb.data_byte    = frame_mem[i];
                    fb.byte_index   = INDEX_W'(i);
                    fb.frame_length = LEN_W'(len);
                    fb.last         = (i == len - 1);
                    frame_beats.push_back(fb);
                end
                // A zero maximum length discards the held bytes with nothing sent
                held    = 0;
                silence = 0;
            end
        endfunction

        // Compare one accepted output beat with the oldest queued frame beat
        function void check_beat(logic [OUT_W-1:0] tdata, logic tlast);
            frame_beat_t want;
            if (frame_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: output beat with nothing queued: tdata=%h tlast=%b",
                             $time, tdata, tlast);
                return;
            end
            want = frame_beats.pop_front();
            if (tdata[7:0] !== want.data_byte || tdata[13:8] !== want.byte_index ||
                tdata[20:14] !== want.frame_length || tdata[23:21] !== 3'b000 ||
                tlast !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: frame beat differs: byte %h/%h index %0d/%0d ",
                              "length %0d/%0d pad %b/000 last %b/%b (got/expected)"},
                             $time, tdata[7:0], want.data_byte, tdata[13:8], want.byte_index,
                             tdata[20:14], want.frame_length, tdata[23:21], tlast, want.last);
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/idle_gap_frame_receiver_core_tb.sv -----
`timescale 1ns / 100ps
// Top-level testbench for idle_gap_frame_receiver_core: stream and register drivers, monitor, watchdog.
// Depends on igfr_pkg and igfr_scoreboard_pkg.
module idle_gap_frame_receiver_core_tb;

    import igfr_pkg::*;
    import igfr_scoreboard_pkg::*;

    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        s_tuser;    // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] data_byte, [13:8] byte_index, [20:14] frame_length
    logic        m_tlast;    // last_of_frame
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();
    bit              no_idling = 1'b0;
    int              sent_beats = 0;
    int              idle_cycles = 0;

    idle_gap_frame_receiver_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the output side in random bursts, none once the tail of the run starts
    initial
    begin
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!no_idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Predict on accepted input beats, check accepted output beats, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_beat(opcode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one input beat, with an occasional random gap ahead of it, and hold until taken
    task automatic send_beat(input opcode_t op, input logic [7:0] value);
        if (!no_idling && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        sent_beats++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_bytes(input int count);
        repeat (count) send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid, let every queued frame beat arrive, then let the block settle
    task automatic stop_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.frame_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle; pready is always high
    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_IDLE_TIMEOUT)
            sb.idle_timeout = value[TIMEOUT_W-1:0];
        else
            sb.max_len = value[LEN_W-1:0];
    endtask

    task automatic configure(input logic [15:0] timeout, input logic [6:0] length);
        stop_stream();
        reg_write(REG_IDLE_TIMEOUT, {16'd0, timeout});
        reg_write(REG_MAX_LEN, {25'd0, length});
    endtask

    // One frame of random bytes with silences of up to the timeout inside, then mostly enough ticks to release it
    task automatic send_frame(input int nbytes);
        int timeout;
        int ticks;
        timeout = sb.idle_timeout;
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_ticks($urandom_range(0, timeout));
            send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        // Now and then stop short of the timeout so the next frame appends to this one
        if ($urandom_range(0, 7) == 0)
            ticks = $urandom_range(0, timeout);
        else
            ticks = timeout + $urandom_range(0, 2);
        send_ticks(ticks);
    endtask

    // Mostly short frames, some long enough to fill the store and drop bytes
    task automatic random_frames(input int beats);
        int first;
        first = sent_beats;
        while (sent_beats - first < beats)
            send_frame(($urandom_range(0, 5) == 0) ? $urandom_range(13, 72)
                                                  : $urandom_range(1, 12));
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= OP_BYTE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ticks on an empty store, then a three-byte frame after ten ticks
        send_ticks(2);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'hA5);
        send_ticks(9);
        send_ticks(1);

        // Zero timeout and a one-byte cap: the first tick sends only the oldest byte
        configure(16'd0, 7'd1);
        send_beat(OP_BYTE, 8'h5A);
        send_beat(OP_BYTE, 8'hC3);
        send_ticks(2);

        // Zero maximum length: held bytes are discarded without output
        configure(16'd0, 7'd0);
        send_beat(OP_BYTE, 8'h81);
        send_beat(OP_BYTE, 8'h7E);
        send_ticks(2);

        configure(16'd1, 7'd64);
        random_frames(PHASE_BEATS);

        // Cap above the store depth: overfill the store, bytes past the depth are dropped
        configure(16'd0, 7'd127);
        send_bytes(70);
        send_ticks(1);
        random_frames(PHASE_BEATS);

        configure(16'd4, 7'd7);
        random_frames(PHASE_BEATS);

        configure(16'd2, 7'd0);
        random_frames(PHASE_BEATS);

        // Largest timeout: a few ticks release nothing, the bytes stay held into the tail
        configure(16'hFFFF, 7'd33);
        send_bytes(40);
        send_ticks(5);

        // Tail of the run with no idling on either side
        no_idling = 1'b1;
        configure(16'd3, 7'd64);
        random_frames(PHASE_BEATS);

        stop_stream();
        if (sb.mismatches == 0 && sb.frame_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            if (sb.frame_beats.size() != 0)
                $display("%0d frame beats never arrived", sb.frame_beats.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
